>>> rtl/osag_pkg.sv
// osag_pkg: shared constants, codes and types of the octet set address generator.
// No dependencies; compiled first.
package osag_pkg;

  localparam int LIST_DEPTH      = 256;
  localparam int NUM_LISTS       = 4;
  localparam int OCTET_W         = 8;
  localparam int POS_W           = 2;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 2;
  localparam int ADDR_W          = 32;
  localparam int COUNT_W         = 9;
  localparam int VAL_ADDR_W      = POS_W + OCTET_W;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_NEXT  = 2'd2,
    OP_CHECK = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_DONE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_CLEAR     = 3'd0,
    K_ADD       = 3'd1,
    K_ADD_EMPTY = 3'd2,
    K_NEXT      = 3'd3,
    K_CHECK     = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [POS_W-1:0]   pos;
    logic [OCTET_W-1:0] lo;
    logic [OCTET_W-1:0] hi;
    logic [ADDR_W-1:0]  query;
  } cmd_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CLR  = 7'b0000010,
    S_ADD  = 7'b0000100,
    S_NXT  = 7'b0001000,
    S_NRD  = 7'b0010000,
    S_CHK  = 7'b0100000,
    S_RESP = 7'b1000000
  } state_e;

endpackage

>>> rtl/osag_if.sv
// osag_if: valid/ready channel interfaces for requests and results.
// Depends on osag_pkg.
interface osag_in_if import osag_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [POS_W-1:0]   octet_position;
  logic [OCTET_W-1:0] value_low;
  logic [OCTET_W-1:0] value_high;
  logic [ADDR_W-1:0]  query_address;

  modport source (output valid, operation, octet_position, value_low, value_high,
                  query_address, input ready);
  modport sink (input valid, operation, octet_position, value_low, value_high,
                query_address, output ready);
endinterface

interface osag_out_if import osag_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   next_address;
  logic                found;

  modport source (output valid, status, next_address, found, input ready);
  modport sink (input valid, status, next_address, found, output ready);
endinterface

>>> rtl/octet_set_address_generator.sv
// octet_set_address_generator: top level; front classifier, command queue, back sequencer.
// Depends on osag_pkg, osag_if, osag_front, osag_fifo, osag_back, osag_ram.
//
//   channel | modport            | payload
//   in_i    | osag_in_if.sink    | operation, octet_position, value_low, value_high,
//           |                    | query_address
//   out_o   | osag_out_if.source | status, next_address, found
//
// The back is paced by the single read port of the membership bitmap and of the
// entry store, one value or octet per cycle. After reset the bitmap is swept to
// zero, and in_i.ready stays low during the sweep.
// The queue takes requests while the back works and a result waits in the output
// register; a stalled out_o holds the back only once it has its next result ready.
module octet_set_address_generator import osag_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  osag_in_if.sink    in_i,
  osag_out_if.source out_o
);

  logic push, pop, full, empty, init_busy;
  cmd_t cmd_in, cmd_out;

  osag_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .hold_i (init_busy),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  osag_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (cmd_out)
  );

  osag_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .init_o  (init_busy),
    .out_o   (out_o)
  );

endmodule

>>> rtl/osag_ram.sv
// osag_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module osag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/osag_front.sv
// osag_front: takes request transfers and classifies them into queue commands.
// Depends on osag_pkg and osag_if.
module osag_front import osag_pkg::*; (
  osag_in_if.sink in_i,
  input  logic    full_i,
  input  logic    hold_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  always_comb begin
    cmd_o.pos   = in_i.octet_position;
    cmd_o.lo    = in_i.value_low;
    cmd_o.hi    = in_i.value_high;
    cmd_o.query = in_i.query_address;
    unique case (op_e'(in_i.operation))
      OP_CLEAR: cmd_o.kind = K_CLEAR;
      // a reversed range is answered without touching the lists
      OP_ADD:   cmd_o.kind = (in_i.value_low > in_i.value_high) ? K_ADD_EMPTY : K_ADD;
      OP_NEXT:  cmd_o.kind = K_NEXT;
      OP_CHECK: cmd_o.kind = K_CHECK;
      default:  cmd_o.kind = K_CHECK;
    endcase
  end

  assign in_i.ready = !full_i && !hold_i;
  assign push_o     = in_i.valid && in_i.ready;

endmodule

>>> rtl/osag_fifo.sv
// osag_fifo: short command queue between the front and the back.
// Depends on osag_pkg.
module osag_fifo import osag_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == CntW'(DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/osag_back.sv
// osag_back: sequencer that executes queued commands against the list stores
// and drives the result register. Depends on osag_pkg, osag_if and osag_ram.
module osag_back import osag_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        init_o,
  osag_out_if.source  out_o
);

  state_e                state_q, state_d;
  logic                  init_q, init_d;
  cmd_t                  cmd_q, cmd_d;
  logic [COUNT_W-1:0]    cnt_q [NUM_LISTS];
  logic [COUNT_W-1:0]    cnt_d [NUM_LISTS];
  logic [COUNT_W-1:0]    cur_q [NUM_LISTS];
  logic [COUNT_W-1:0]    cur_d [NUM_LISTS];
  logic [OCTET_W-1:0]    snap_q [NUM_LISTS];
  logic [OCTET_W-1:0]    snap_d [NUM_LISTS];
  logic [OCTET_W-1:0]    sweep_q, sweep_d;
  logic [OCTET_W-1:0]    iter_q, iter_d;
  logic [OCTET_W-1:0]    pv_q, pv_d;
  logic                  issued_q, issued_d;
  logic                  pend_q, pend_d;
  logic                  dup_q, dup_d;
  logic [2:0]            step_q, step_d;
  status_e               res_status_q, res_status_d;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  logic                  res_found_q, res_found_d;
  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q;
  logic [ADDR_W-1:0]     out_addr_q;
  logic                  out_found_q;
  logic                  out_load;

  // membership bitmap: one word per octet value, one bit per list
  logic                  bm_we;
  logic [OCTET_W-1:0]    bm_waddr, bm_raddr;
  logic [NUM_LISTS-1:0]  bm_wdata, bm_rdata;
  // list entries, row per list
  logic                  val_we;
  logic [VAL_ADDR_W-1:0] val_waddr, val_raddr;
  logic [OCTET_W-1:0]    val_wdata, val_rdata;

  // cursor walk helpers
  logic [COUNT_W-1:0]    eff [NUM_LISTS];
  logic [COUNT_W-1:0]    inc [NUM_LISTS];
  logic [COUNT_W-1:0]    nxt [NUM_LISTS];
  logic                  any_empty;
  logic                  exhausted;
  logic [POS_W-1:0]      sidx;
  logic [POS_W-1:0]      pidx;
  logic [POS_W-1:0]      qsel;
  logic                  hit;

  osag_ram #(.WIDTH(NUM_LISTS), .DEPTH(LIST_DEPTH)) u_bm_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  osag_ram #(.WIDTH(OCTET_W), .DEPTH(NUM_LISTS * LIST_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  always_comb begin
    any_empty = 1'b0;
    for (int p = 0; p < NUM_LISTS; p++) begin
      if (cnt_q[p] == '0) any_empty = 1'b1;
      eff[p] = (cur_q[p] >= cnt_q[p]) ? '0 : cur_q[p];
      inc[p] = eff[p] + 1'b1;
      nxt[p] = eff[p];
    end
    exhausted = (cur_q[0] >= cnt_q[0]);
    // mixed-radix step, last position fastest
    if (inc[3] < cnt_q[3]) begin
      nxt[3] = inc[3];
    end else begin
      nxt[3] = '0;
      if (inc[2] < cnt_q[2]) begin
        nxt[2] = inc[2];
      end else begin
        nxt[2] = '0;
        if (inc[1] < cnt_q[1]) begin
          nxt[1] = inc[1];
        end else begin
          nxt[1] = '0;
          nxt[0] = inc[0];
        end
      end
    end
  end

  assign sidx = step_q[POS_W-1:0];
  assign pidx = sidx - 1'b1;
  assign qsel = 2'd3 - sidx;
  assign hit  = bm_rdata[cmd_q.pos];

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    cmd_d        = cmd_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    snap_d       = snap_q;
    sweep_d      = sweep_q;
    iter_d       = iter_q;
    pv_d         = pv_q;
    issued_d     = issued_q;
    pend_d       = pend_q;
    dup_d        = dup_q;
    step_d       = step_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_found_d  = res_found_q;
    out_valid_d  = out_valid_q;
    out_load     = 1'b0;
    pop_o        = 1'b0;
    bm_we        = 1'b0;
    bm_waddr     = pv_q;
    bm_wdata     = '0;
    bm_raddr     = iter_q;
    val_we       = 1'b0;
    val_waddr    = {cmd_q.pos, cnt_q[cmd_q.pos][OCTET_W-1:0]};
    val_wdata    = pv_q;
    val_raddr    = {sidx, snap_q[sidx]};

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o        = 1'b1;
          cmd_d        = cmd_i;
          res_status_d = ST_OK;
          res_addr_d   = '0;
          res_found_d  = 1'b0;
          step_d       = '0;
          case (cmd_i.kind)
            K_CLEAR: begin
              for (int p = 0; p < NUM_LISTS; p++) begin
                cnt_d[p] = '0;
                cur_d[p] = '0;
              end
              sweep_d = '0;
              state_d = S_CLR;
            end
            K_ADD: begin
              iter_d   = cmd_i.lo;
              issued_d = 1'b0;
              pend_d   = 1'b0;
              dup_d    = 1'b0;
              state_d  = S_ADD;
            end
            K_NEXT: state_d = S_NXT;
            K_CHECK: begin
              res_found_d = 1'b1;
              state_d     = S_CHK;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_CLR: begin
        bm_we    = 1'b1;
        bm_waddr = sweep_q;
        bm_wdata = '0;
        sweep_d  = sweep_q + 1'b1;
        if (sweep_q == '1) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_RESP;
        end
      end
      S_ADD: begin
        // bitmap read for one value issues while the previous one is written
        if (!issued_q) begin
          bm_raddr = iter_q;
          pend_d   = 1'b1;
          pv_d     = iter_q;
          if (iter_q == cmd_q.hi) issued_d = 1'b1;
          else iter_d = iter_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (hit) begin
            dup_d = 1'b1;
          end else if (!cnt_q[cmd_q.pos][COUNT_W-1]) begin
            val_we              = 1'b1;
            bm_we               = 1'b1;
            bm_wdata            = bm_rdata | (NUM_LISTS'(1) << cmd_q.pos);
            cnt_d[cmd_q.pos]    = cnt_q[cmd_q.pos] + 1'b1;
          end
          if (issued_q) begin
            res_status_d = (dup_q || hit) ? ST_DUP : ST_OK;
            state_d      = S_RESP;
          end
        end
      end
      S_NXT: begin
        if (any_empty) begin
          for (int p = 0; p < NUM_LISTS; p++) cur_d[p] = '0;
          res_status_d = ST_DONE;
          state_d      = S_RESP;
        end else if (exhausted) begin
          cur_d[0]     = '0;
          res_status_d = ST_DONE;
          state_d      = S_RESP;
        end else begin
          for (int p = 0; p < NUM_LISTS; p++) begin
            cur_d[p]  = nxt[p];
            snap_d[p] = eff[p][OCTET_W-1:0];
          end
          step_d  = '0;
          state_d = S_NRD;
        end
      end
      S_NRD: begin
        // one entry read per cycle, first octet shifted in first
        if (step_q != 3'd0) res_addr_d = {res_addr_q[ADDR_W-OCTET_W-1:0], val_rdata};
        step_d = step_q + 1'b1;
        if (step_q == 3'd4) state_d = S_RESP;
      end
      S_CHK: begin
        bm_raddr = cmd_q.query[{qsel, 3'b000} +: OCTET_W];
        if (step_q != 3'd0) res_found_d = res_found_q & bm_rdata[pidx];
        step_d = step_q + 1'b1;
        if (step_q == 3'd4) state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      init_q      <= 1'b1;
      sweep_q     <= '0;
      issued_q    <= 1'b0;
      pend_q      <= 1'b0;
      dup_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      for (int p = 0; p < NUM_LISTS; p++) begin
        cnt_q[p] <= '0;
        cur_q[p] <= '0;
      end
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      sweep_q     <= sweep_d;
      issued_q    <= issued_d;
      pend_q      <= pend_d;
      dup_q       <= dup_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    snap_q       <= snap_d;
    iter_q       <= iter_d;
    pv_q         <= pv_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_found_q  <= res_found_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_found_q  <= res_found_q;
    end
  end

  assign init_o             = init_q;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.next_address = out_addr_q;
  assign out_o.found        = out_found_q;

endmodule

>>> rtl/osag_chk.sv
// osag_chk: port-level checker for the octet set address generator, with its bind.
// Depends on osag_pkg and octet_set_address_generator.
module osag_chk import osag_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [ADDR_W-1:0]   next_address_i,
  input logic                found_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(status_i) && $stable(next_address_i) && $stable(found_i))
    else $error("result payload changed while stalled");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_DONE || status_i == ST_DUP) |->
      next_address_i == '0 && !found_i)
    else $error("done or duplicate result carries an address or a hit");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> status_i == ST_OK && next_address_i == '0)
    else $error("membership hit with nonzero status or address");

endmodule

bind octet_set_address_generator osag_chk u_osag_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .next_address_i (out_o.next_address),
  .found_i        (out_o.found)
);
